// ===== rtl/hse_pkg.sv =====
// Package for the heap sort engine: sizing constants and the record type.
// No dependencies.
package hse_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int KEY_BITS    = 32;

  localparam int PORT_KEY_W  = 32;
  localparam int TAG_W       = 16;
  // Bits of a key that take part in the sort
  localparam int KEY_W       = (KEY_BITS < PORT_KEY_W) ? KEY_BITS : PORT_KEY_W;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } record_t;

endpackage

// ===== rtl/heap_sort_engine.sv =====
// Heap sort engine top level: record store, heapsort sequencer and result output.
// Depends on hse_pkg.
//
//  - Records load through start / busy: a transfer happens at a rising edge with start
//    high and busy low, carrying sort_key_i, record_tag_i and last_record_i. Loading
//    takes a new record every cycle; busy stays low.
//  - A record with last_record_i set ends the set; busy then rises and the records are
//    heapsorted in place in a dual-read, single-write store. A sift starts by reading
//    the record to move, then for each level it descends reads the children, compares
//    and moves, and ends by writing the moving record; a set of N records runs N/2 build
//    sifts and N - 1 sort sifts.
//  - The sorted run follows one record a cycle on sorted_key_o / sorted_tag_o, each
//    marked by result_strobe_o for one cycle and read registered from the store after the
//    last sort step (after the load for a one-record set); end_of_run_o flags the final
//    one and overflowed_o the whole run if a load found the store full and was dropped.
//  - busy falls in the cycle of the final result; the receiver cannot stall.
//  - cfg_we_i / cfg_wdata_i set the order (0 ascending, 1 descending); write it only
//    while busy is low.
//  - Reset empties the store count, clears the overflow flag and selects ascending
//    order. Store contents are not cleared.
module heap_sort_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [hse_pkg::PORT_KEY_W-1:0] sort_key_i,
  input  logic [hse_pkg::TAG_W-1:0]     record_tag_i,
  input  logic                          last_record_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  output logic                          result_strobe_o,
  output logic [hse_pkg::PORT_KEY_W-1:0] sorted_key_o,
  output logic [hse_pkg::TAG_W-1:0]     sorted_tag_o,
  output logic                          end_of_run_o,
  output logic                          overflowed_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD_RD,
    S_BUILD_MK,
    S_SWAP_RD,
    S_SWAP_WR,
    S_CHILD,
    S_CMP,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic              build_q, build_d;
  hse_pkg::addr_t    i_q, i_d;
  hse_pkg::addr_t    pos_q, pos_d;
  hse_pkg::addr_t    last_q, last_d;
  hse_pkg::addr_t    k_q, k_d;
  hse_pkg::cnt_t     n_q, n_d;
  hse_pkg::cnt_t     cnt_q, cnt_d;
  hse_pkg::record_t  mk_q, mk_d;
  logic              ovf_q, ovf_d;
  logic              desc_q, desc_d;
  logic              strobe_q, strobe_d;
  logic              end_q, end_d;
  logic              ovfo_q, ovfo_d;

  // record store
  hse_pkg::record_t  mem_q [hse_pkg::MAX_RECORDS];
  logic              we;
  hse_pkg::addr_t    waddr;
  hse_pkg::record_t  wdata;
  hse_pkg::addr_t    raddr_a, raddr_b;
  hse_pkg::record_t  rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
  end

  // sift-down datapath
  logic [hse_pkg::ADDR_W:0] child;
  logic [hse_pkg::ADDR_W:0] last_ext;
  logic                     has_child, has_right;
  logic                     lt_lr, take_right, stop_sift;
  hse_pkg::record_t         pick;
  logic                     sift_end;
  logic                     full;
  hse_pkg::cnt_t            n_new;

  assign child     = {pos_q, 1'b1};
  assign last_ext  = {1'b0, last_q};
  assign has_child = (child <= last_ext);
  assign has_right = (child < last_ext);
  assign lt_lr     = (rd_a_q.key < rd_b_q.key);
  // ascending takes the left child on a tie, descending the right one
  assign take_right = has_right && (desc_q ? !lt_lr : lt_lr);
  assign pick       = take_right ? rd_b_q : rd_a_q;
  assign stop_sift  = desc_q ? (mk_q.key < pick.key) : !(mk_q.key < pick.key);
  assign full       = (cnt_q == hse_pkg::CNT_W'(hse_pkg::MAX_RECORDS));
  assign n_new      = full ? cnt_q : cnt_q + hse_pkg::CNT_W'(1);

  always_comb begin
    state_d  = state_q;
    build_d  = build_q;
    i_d      = i_q;
    pos_d    = pos_q;
    last_d   = last_q;
    k_d      = k_q;
    n_d      = n_q;
    cnt_d    = cnt_q;
    mk_d     = mk_q;
    ovf_d    = ovf_q;
    desc_d   = desc_q;
    strobe_d = 1'b0;
    end_d    = 1'b0;
    ovfo_d   = ovfo_q;
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = mk_q;
    raddr_a  = i_q;
    raddr_b  = i_q;
    sift_end = 1'b0;

    if (cfg_we_i) begin
      desc_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            we    = 1'b1;
            waddr = cnt_q[hse_pkg::ADDR_W-1:0];
            wdata = '{key: sort_key_i[hse_pkg::KEY_W-1:0], tag: record_tag_i};
            cnt_d = n_new;
          end
          if (last_record_i) begin
            n_d = n_new;
            k_d = '0;
            if (n_new >= hse_pkg::CNT_W'(2)) begin
              build_d = 1'b1;
              i_d     = hse_pkg::ADDR_W'((n_new >> 1) - hse_pkg::CNT_W'(1));
              last_d  = hse_pkg::ADDR_W'(n_new - hse_pkg::CNT_W'(1));
              state_d = S_BUILD_RD;
            end else begin
              state_d = S_OUT;
            end
          end
        end
      end
      S_BUILD_RD: begin
        raddr_a = i_q;
        state_d = S_BUILD_MK;
      end
      S_BUILD_MK: begin
        mk_d    = rd_a_q;
        pos_d   = i_q;
        state_d = S_CHILD;
      end
      S_SWAP_RD: begin
        raddr_a = '0;
        raddr_b = i_q;
        state_d = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        // root goes to the end; the old end record sifts down from the root
        we      = 1'b1;
        waddr   = i_q;
        wdata   = rd_a_q;
        mk_d    = rd_b_q;
        pos_d   = '0;
        last_d  = i_q - hse_pkg::ADDR_W'(1);
        state_d = S_CHILD;
      end
      S_CHILD: begin
        if (has_child) begin
          raddr_a = child[hse_pkg::ADDR_W-1:0];
          raddr_b = has_right ? child[hse_pkg::ADDR_W-1:0] + hse_pkg::ADDR_W'(1)
                              : child[hse_pkg::ADDR_W-1:0];
          state_d = S_CMP;
        end else begin
          we       = 1'b1;
          sift_end = 1'b1;
        end
      end
      S_CMP: begin
        we = 1'b1;
        if (stop_sift) begin
          sift_end = 1'b1;
        end else begin
          wdata   = pick;
          pos_d   = take_right ? child[hse_pkg::ADDR_W-1:0] + hse_pkg::ADDR_W'(1)
                               : child[hse_pkg::ADDR_W-1:0];
          state_d = S_CHILD;
        end
      end
      S_OUT: begin
        raddr_a  = k_q;
        strobe_d = 1'b1;
        ovfo_d   = ovf_q;
        if (k_q == hse_pkg::ADDR_W'(n_q - hse_pkg::CNT_W'(1))) begin
          end_d   = 1'b1;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + hse_pkg::ADDR_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (sift_end) begin
      if (build_q) begin
        if (i_q == '0) begin
          build_d = 1'b0;
          i_d     = hse_pkg::ADDR_W'(n_q - hse_pkg::CNT_W'(1));
          state_d = S_SWAP_RD;
        end else begin
          i_d     = i_q - hse_pkg::ADDR_W'(1);
          state_d = S_BUILD_RD;
        end
      end else if (i_q == hse_pkg::ADDR_W'(1)) begin
        k_d     = '0;
        state_d = S_OUT;
      end else begin
        i_d     = i_q - hse_pkg::ADDR_W'(1);
        state_d = S_SWAP_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      build_q  <= 1'b0;
      i_q      <= '0;
      pos_q    <= '0;
      last_q   <= '0;
      k_q      <= '0;
      n_q      <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      desc_q   <= 1'b0;
      strobe_q <= 1'b0;
      end_q    <= 1'b0;
      ovfo_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      build_q  <= build_d;
      i_q      <= i_d;
      pos_q    <= pos_d;
      last_q   <= last_d;
      k_q      <= k_d;
      n_q      <= n_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      desc_q   <= desc_d;
      strobe_q <= strobe_d;
      end_q    <= end_d;
      ovfo_q   <= ovfo_d;
    end
  end

  // moving record needs no reset
  always_ff @(posedge clk_i) begin
    mk_q <= mk_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign result_strobe_o = strobe_q;
  assign sorted_key_o    = hse_pkg::PORT_KEY_W'(rd_a_q.key);
  assign sorted_tag_o    = rd_a_q.tag;
  assign end_of_run_o    = end_q;
  assign overflowed_o    = ovfo_q;

`ifndef ASSERT_OFF
  // a record not marked last never starts a sort
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !last_record_i) |=> !busy)
    else $error("block left idle on a non-final load");

  // a result that is not the final one means more of the run is coming
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !end_of_run_o) |-> busy)
    else $error("run stopped before its final record");

  a_end_marks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_run_o |-> result_strobe_o)
    else $error("end of run without a result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hse_pkg::CNT_W'(hse_pkg::MAX_RECORDS))
    else $error("record count beyond capacity");

  // sift moves stay inside the current heap
  a_sift_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (pos_q < last_q))
    else $error("sift compare outside heap");
`endif

endmodule

// ===== tb/tb_heap_sort_engine.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for heap_sort_engine: loads record sets, predicts the sorted
// run with a heapsort of its own and checks every result record. Depends on hse_pkg.
module tb_heap_sort_engine;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_RECORDS  = 60;

  typedef struct packed {
    logic [hse_pkg::PORT_KEY_W-1:0] key;
    hse_pkg::tag_t                  tag;
    logic                           eor;
    logic                           ovf;
  } sorted_rec_t;

  typedef enum int {KEYS_ANY, KEYS_TIED, KEYS_EXTREME} key_mix_e;

  class run_checker;
    hse_pkg::key_t rec_key[hse_pkg::MAX_RECORDS];
    hse_pkg::tag_t rec_tag[hse_pkg::MAX_RECORDS];
    int unsigned   stored;
    bit            dropped;
    bit            descending;
    sorted_rec_t   sorted_run_q[$];
    int unsigned   fails;

    function void sift_down(int pos, int last);
      hse_pkg::key_t mk;
      hse_pkg::tag_t mt;
      int            c;
      bit            lt;
      bit            stop;
      mk = rec_key[pos];
      mt = rec_tag[pos];
      c = 2 * pos + 1;
      stop = 0;
      while (c <= last && !stop) begin
        if (c < last) begin
          lt = rec_key[c] < rec_key[c+1];
          if (descending ? !lt : lt) c = c + 1;
        end
        // min-heap keeps sifting on equal keys, max-heap stops
        if (descending ? (mk < rec_key[c]) : !(mk < rec_key[c])) begin
          stop = 1;
        end else begin
          rec_key[pos] = rec_key[c];
          rec_tag[pos] = rec_tag[c];
          pos = c;
          c = 2 * pos + 1;
        end
      end
      rec_key[pos] = mk;
      rec_tag[pos] = mt;
    endfunction

    function void heap_sort_records(int n);
      hse_pkg::key_t k;
      hse_pkg::tag_t t;
      for (int i = n / 2 - 1; i >= 0; i--) sift_down(i, n - 1);
      for (int i = n - 1; i >= 0; i--) begin
        k = rec_key[i];
        t = rec_tag[i];
        rec_key[i] = rec_key[0];
        rec_tag[i] = rec_tag[0];
        rec_key[0] = k;
        rec_tag[0] = t;
        sift_down(0, i - 1);
      end
    endfunction

    function void note_record(logic [hse_pkg::PORT_KEY_W-1:0] key, hse_pkg::tag_t tag,
                              logic last);
      sorted_rec_t r;
      if (stored < hse_pkg::MAX_RECORDS) begin
        rec_key[stored] = hse_pkg::key_t'(key);
        rec_tag[stored] = tag;
        stored++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      heap_sort_records(stored);
      for (int k = 0; k < stored; k++) begin
        r.key = hse_pkg::PORT_KEY_W'(rec_key[k]);
        r.tag = rec_tag[k];
        r.eor = (k == stored - 1);
        r.ovf = dropped;
        sorted_run_q.push_back(r);
      end
      stored = 0;
      dropped = 0;
    endfunction

    function void check_result(logic [hse_pkg::PORT_KEY_W-1:0] key, hse_pkg::tag_t tag,
                               logic eor, logic ovf);
      sorted_rec_t e;
      if (sorted_run_q.size() == 0) begin
        $display("%0t: unexpected result key %h tag %h eor %b ovf %b",
                 $time, key, tag, eor, ovf);
        fails++;
        return;
      end
      e = sorted_run_q.pop_front();
      if (key !== e.key) begin
        $display("%0t: sorted_key expected %h actual %h", $time, e.key, key);
        fails++;
      end
      if (tag !== e.tag) begin
        $display("%0t: sorted_tag expected %h actual %h", $time, e.tag, tag);
        fails++;
      end
      if (eor !== e.eor) begin
        $display("%0t: end_of_run expected %b actual %b", $time, e.eor, eor);
        fails++;
      end
      if (ovf !== e.ovf) begin
        $display("%0t: overflowed expected %b actual %b", $time, e.ovf, ovf);
        fails++;
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [hse_pkg::PORT_KEY_W-1:0] sort_key_i;
  hse_pkg::tag_t                  record_tag_i;
  logic                           last_record_i;
  logic                           cfg_we_i;
  logic                           cfg_wdata_i;
  logic                           result_strobe_o;
  logic [hse_pkg::PORT_KEY_W-1:0] sorted_key_o;
  hse_pkg::tag_t                  sorted_tag_o;
  logic                           end_of_run_o;
  logic                           overflowed_o;

  run_checker sb;
  int         quiet_cycles = 0;

  heap_sort_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sort_key_i      (sort_key_i),
    .record_tag_i    (record_tag_i),
    .last_record_i   (last_record_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_strobe_o (result_strobe_o),
    .sorted_key_o    (sorted_key_o),
    .sorted_tag_o    (sorted_tag_o),
    .end_of_run_o    (end_of_run_o),
    .overflowed_o    (overflowed_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Monitor and watchdog: results first, then the record transfer of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_strobe_o)
        sb.check_result(sorted_key_o, sorted_tag_o, end_of_run_o, overflowed_o);
      if (start && !busy)
        sb.note_record(sort_key_i, record_tag_i, last_record_i);
      if (result_strobe_o || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog expired", $time);
          $display("tb_heap_sort_engine NOT OK");
          $finish;
        end
      end
    end
  end

  task automatic load_record(logic [hse_pkg::PORT_KEY_W-1:0] key, hse_pkg::tag_t tag,
                             logic last, int idle_pct);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start         = 1'b1;
    sort_key_i    = key;
    record_tag_i  = tag;
    last_record_i = last;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.sorted_run_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_order(bit desc);
    pause_until_drained();
    @(negedge clk_i);
    cfg_we_i      = 1'b1;
    cfg_wdata_i   = desc;
    sb.descending = desc;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [hse_pkg::PORT_KEY_W-1:0] pick_key(key_mix_e mix);
    case (mix)
      KEYS_TIED: return hse_pkg::PORT_KEY_W'($urandom_range(0, 3));
      KEYS_EXTREME: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic load_set(int size, key_mix_e mix, int idle_pct);
    for (int i = 0; i < size; i++)
      load_record(pick_key(mix), hse_pkg::tag_t'($urandom_range(0, 65535)),
                  i == size - 1, idle_pct);
  endtask

  initial begin
    int       idle_pct[4];
    int       loaded;
    int       size;
    key_mix_e mix;
    idle_pct = '{0, 48, 0, 11};
    sb = new;
    rst_ni        = 1'b0;
    start         = 1'b0;
    sort_key_i    = '0;
    record_tag_i  = '0;
    last_record_i = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: single-record sets, key and tag extremes, ties in both orders
    write_order(1'b0);
    load_record('1, '1, 1'b1, 0);
    load_record('0, 16'h0001, 1'b0, 0);
    load_record('1, 16'h0002, 1'b0, 0);
    load_record(32'd5, 16'h0003, 1'b0, 0);
    load_record(32'd5, 16'h0004, 1'b1, 0);
    load_record(32'd9, 16'hAAAA, 1'b0, 0);
    load_record(32'd9, 16'h5555, 1'b1, 0);
    write_order(1'b1);
    load_record(32'd7, 16'h0011, 1'b0, 0);
    load_record(32'd7, 16'h0012, 1'b0, 0);
    load_record('0, 16'h0013, 1'b0, 0);
    load_record('1, 16'h0014, 1'b0, 0);
    load_record(32'd7, 16'h0015, 1'b1, 0);
    load_record('0, '0, 1'b1, 0);
    load_record(32'd3, 16'hFFFF, 1'b0, 0);
    load_record(32'd3, 16'h0000, 1'b1, 0);

    // Random sets: mostly short, a few at and beyond the store capacity
    for (int p = 0; p < 8; p++) begin
      write_order(1'(p % 2));
      loaded = 0;
      while (loaded < PHASE_RECORDS) begin
        case ($urandom_range(0, 19))
          0:       size = $urandom_range(62, 70);
          1, 2:    size = $urandom_range(13, 40);
          default: size = $urandom_range(1, 12);
        endcase
        if (loaded == 0 && p == 2) size = hse_pkg::MAX_RECORDS;
        if (loaded == 0 && p == 5) size = hse_pkg::MAX_RECORDS + 1;
        if (loaded == 0 && p == 7) size = hse_pkg::MAX_RECORDS + 6;
        mix = key_mix_e'($urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0) pause_until_drained();
        load_set(size, mix, idle_pct[p / 2]);
        loaded += size;
      end
    end

    pause_until_drained();
    repeat (20) @(posedge clk_i);
    if (sb.sorted_run_q.size() != 0)
      $display("%0t: %0d sorted records never arrived", $time, sb.sorted_run_q.size());
    if (sb.fails == 0 && sb.sorted_run_q.size() == 0) begin
      $display("tb_heap_sort_engine OK");
    end else begin
      $display("tb_heap_sort_engine NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hse_pkg.sv
rtl/heap_sort_engine.sv
tb/tb_heap_sort_engine.sv
